FILE: rtl/core/cmux_basic_frame_builder_assert.svh
// Assertion macros for the multiplexer frame builder.
// Uses no package; included by the top level only.
`ifndef CMUX_BASIC_FRAME_BUILDER_ASSERT_SVH
`define CMUX_BASIC_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CMUX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CMUX_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/cmux_pkg.sv
// Shared types, constants and the CRC-8 step for the multiplexer frame builder.
// No dependencies; used by every module of the block.
package cmux_pkg;

   localparam int LEN_W           = 15;   // width of the payload length field
   localparam int LENGTH_BITS_DEF = 15;
   localparam int REQ_TDATA_W     = 40;
   localparam int RSP_TDATA_W     = 8;
   localparam int RSP_TUSER_W     = 2;
   localparam int SHORT_LEN_MAX   = 127;  // longest length sent in one byte

   localparam logic [7:0] FLAG_BYTE     = 8'hF9;
   localparam logic [7:0] UIH_CODE      = 8'hEF;
   localparam logic [7:0] PF_BIT        = 8'h10;
   localparam logic [7:0] CRC_INIT      = 8'hFF;
   localparam logic [7:0] CRC_POLY_REFL = 8'hE0;

   localparam logic CMD_HEADER  = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   typedef enum logic [3:0] {
      ST_FLAG,
      ST_ADDR,
      ST_CTRL,
      ST_LEN0,
      ST_LEN1,
      ST_DATA,
      ST_FCS,
      ST_CLOSE
   } step_type;

   typedef struct packed {
      logic              cmd;
      logic [5:0]        dlci;
      logic              is_command;
      logic [7:0]        frame_type;
      logic              poll_bit;
      logic [LEN_W-1:0]  payload_length;
      logic [7:0]        data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_last;
      logic       error;
   } rsp_item_type;

   // One byte through the reflected CRC-8, eight bit steps.
   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/cmux_basic_frame_builder.sv
// Top level of the basic-mode multiplexer frame builder.
// Depends on cmux_pkg, cmux_sequencer, cmux_skid and the assertion macro header.
//
// A header request (tuser 0) opens a frame and yields the opening flag, the
// address byte, the control byte and one length byte (lengths up to 127) or
// two, followed at once by the FCS and closing flag when the length is zero.
// Each payload request (tuser 1) yields its byte, plus FCS and closing flag
// after the last payload byte of the frame; a payload request with no open
// frame yields one byte 0 with the error flag. A header aborts an open frame
// without closing bytes. The block sends one result byte per cycle unless
// stalled, through a single byte lane; the next request is taken in the
// cycle the previous one's last byte moves into the two-entry output stage,
// so payload bytes stream at one per cycle. The FCS is the complement of a
// reflected CRC-8 (polynomial 0x07, start 0xFF) updated one byte per cycle as
// bytes leave the sequencer; it covers address and control, the length bytes
// when basic_mode is 1, and the payload unless the frame is UIH. Write
// basic_mode (reset 1) only while the block is idle. rsp_tlast marks the last
// byte caused by a request. Lengths wider than LENGTH_BITS saturate to the
// largest that fits.
`include "cmux_basic_frame_builder_assert.svh"

module cmux_basic_frame_builder #(
   parameter int LENGTH_BITS = cmux_pkg::LENGTH_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: dlci[5:0], is_command[6], frame_type[14:7], poll_bit[15],
   //        payload_length[30:16], data_byte[38:31], zero[39]
   input  logic [cmux_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: cmd[0]
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: out_byte[7:0]
   output logic [cmux_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // tuser: frame_last[0], error[1]
   output logic [cmux_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);

   logic                   basic_mode_ff;
   cmux_pkg::req_item_type req_item;
   logic                   seq_valid;
   logic                   seq_ready;
   cmux_pkg::rsp_item_type seq_res;
   cmux_pkg::rsp_item_type out_res;

   // Unpack the request fields from the stream word
   assign req_item.cmd            = req_tuser;
   assign req_item.dlci           = req_tdata[5:0];
   assign req_item.is_command     = req_tdata[6];
   assign req_item.frame_type     = req_tdata[14:7];
   assign req_item.poll_bit       = req_tdata[15];
   assign req_item.payload_length = req_tdata[30:16];
   assign req_item.data_byte      = req_tdata[38:31];

   // Hold the mode register; the user must write it only between frames, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         basic_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         basic_mode_ff <= csr_wr_data;
      end
   end

   // Sequence one byte per cycle from the held request, while the skid stage accepts
   cmux_sequencer #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .basic_mode (basic_mode_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .res_valid  (seq_valid),
      .res_ready  (seq_ready),
      .res_item   (seq_res)
   );

   // Decouple the sequencer from output back-pressure
   cmux_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seq_valid),
      .in_ready  (seq_ready),
      .in_data   (seq_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tdata = out_res.out_byte;
   assign rsp_tlast = out_res.run_last;
   assign rsp_tuser = {out_res.error, out_res.frame_last};

   // A closing flag always ends the request that caused it
   `CMUX_ASSERT_IMP(a_close_ends_run, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast, "closing flag without tlast")
   // An error result is a lone zero byte outside any frame
   `CMUX_ASSERT_IMP(a_error_shape, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast && !rsp_tuser[0] && rsp_tdata == 8'h00, "malformed error result")
   // A stalled sequencer result must not drift while frame state holds
   `CMUX_ASSERT_NXT(a_seq_hold, clock, reset, seq_valid && !seq_ready, seq_valid && $stable(seq_res), "sequencer result changed under stall")

endmodule

FILE: rtl/core/cmux_skid.sv
// Two-entry output skid stage for result bytes.
// Depends on cmux_pkg for the result type.
module cmux_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cmux_pkg::rsp_item_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cmux_pkg::rsp_item_type out_data
);

   logic                   main_valid_ff;
   logic                   skid_valid_ff;
   cmux_pkg::rsp_item_type main_data_ff;
   cmux_pkg::rsp_item_type skid_data_ff;
   logic                   in_fire;
   logic                   out_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (in_fire) begin
         if (!main_valid_ff || out_fire) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         if (!main_valid_ff || out_fire) begin
            main_data_ff <= in_data;
         end else begin
            skid_data_ff <= in_data;
         end
      end else if (out_fire && skid_valid_ff) begin
         main_data_ff <= skid_data_ff;
      end
   end

endmodule

FILE: rtl/core/cmux_sequencer.sv
// Request register, byte sequencer and frame state (CRC, length, open flag).
// Depends on cmux_pkg for types, constants and the CRC step.
module cmux_sequencer #(
   parameter int LENGTH_BITS = cmux_pkg::LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   basic_mode,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cmux_pkg::req_item_type req_item,
   output logic                   res_valid,
   input  logic                   res_ready,
   output cmux_pkg::rsp_item_type res_item
);

   localparam int LW = cmux_pkg::LEN_W;
   localparam logic [LW-1:0] LEN_MAX = LW'((1 << LENGTH_BITS) - 1);

   cmux_pkg::req_item_type  item_ff;
   logic                    item_valid_ff;
   cmux_pkg::step_type      step_ff;
   cmux_pkg::step_type      step_in;
   logic                    step_end;

   logic [7:0]              crc_ff, crc_in;
   logic [LENGTH_BITS-1:0]  bytes_left_ff, bytes_left_in;
   logic                    frame_open_ff, frame_open_in;
   logic                    payload_in_crc_ff, payload_in_crc_in;

   logic                    advance;
   logic                    req_fire;
   logic [LW-1:0]           len_sat;
   logic                    two_len;
   logic                    len_zero;
   logic [7:0]              addr_byte, ctrl_byte, len0_byte, len1_byte;
   logic                    is_uih;
   logic [LENGTH_BITS-1:0]  left_dec;

   assign advance   = item_valid_ff && res_ready;
   assign req_ready = !item_valid_ff || (advance && step_end);
   assign req_fire  = req_valid && req_ready;
   assign res_valid = item_valid_ff;

   // Header fields of the held request
   assign len_sat   = (item_ff.payload_length > LEN_MAX) ? LEN_MAX : item_ff.payload_length;
   assign two_len   = len_sat > LW'(cmux_pkg::SHORT_LEN_MAX);
   assign len_zero  = len_sat == '0;
   assign addr_byte = {item_ff.dlci, item_ff.is_command, 1'b1};
   assign ctrl_byte = item_ff.frame_type | (item_ff.poll_bit ? cmux_pkg::PF_BIT : 8'h00);
   assign len0_byte = {len_sat[6:0], !two_len};
   assign len1_byte = len_sat[LW-1:7];
   assign is_uih    = (item_ff.frame_type & cmux_pkg::UIH_CODE) == cmux_pkg::UIH_CODE;
   assign left_dec  = (bytes_left_ff != '0) ? bytes_left_ff - LENGTH_BITS'(1) : '0;

   // Next step and end of the current request
   always_comb begin
      step_in  = step_ff;
      step_end = 1'b0;
      case (step_ff)
         cmux_pkg::ST_FLAG:  step_in = cmux_pkg::ST_ADDR;
         cmux_pkg::ST_ADDR:  step_in = cmux_pkg::ST_CTRL;
         cmux_pkg::ST_CTRL:  step_in = cmux_pkg::ST_LEN0;
         cmux_pkg::ST_LEN0: begin
            if (two_len) begin
               step_in = cmux_pkg::ST_LEN1;
            end else if (len_zero) begin
               step_in = cmux_pkg::ST_FCS;
            end else begin
               step_end = 1'b1;
            end
         end
         cmux_pkg::ST_LEN1: begin
            if (len_zero) begin
               step_in = cmux_pkg::ST_FCS;
            end else begin
               step_end = 1'b1;
            end
         end
         cmux_pkg::ST_DATA: begin
            if (frame_open_ff && left_dec == '0) begin
               step_in = cmux_pkg::ST_FCS;
            end else begin
               step_end = 1'b1;
            end
         end
         cmux_pkg::ST_FCS:   step_in = cmux_pkg::ST_CLOSE;
         cmux_pkg::ST_CLOSE: step_end = 1'b1;
         default:            step_end = 1'b1;
      endcase
   end

   // Result byte and frame state update for the current step
   always_comb begin
      res_item.out_byte   = 8'h00;
      res_item.run_last   = step_end;
      res_item.frame_last = 1'b0;
      res_item.error      = 1'b0;
      crc_in              = crc_ff;
      bytes_left_in       = bytes_left_ff;
      frame_open_in       = frame_open_ff;
      payload_in_crc_in   = payload_in_crc_ff;
      case (step_ff)
         cmux_pkg::ST_FLAG: begin
            res_item.out_byte = cmux_pkg::FLAG_BYTE;
            crc_in            = cmux_pkg::CRC_INIT;
            frame_open_in     = 1'b1;
            payload_in_crc_in = !is_uih;
            bytes_left_in     = len_sat[LENGTH_BITS-1:0];
         end
         cmux_pkg::ST_ADDR: begin
            res_item.out_byte = addr_byte;
            crc_in            = cmux_pkg::crc_feed(crc_ff, addr_byte);
         end
         cmux_pkg::ST_CTRL: begin
            res_item.out_byte = ctrl_byte;
            crc_in            = cmux_pkg::crc_feed(crc_ff, ctrl_byte);
         end
         cmux_pkg::ST_LEN0: begin
            res_item.out_byte = len0_byte;
            if (basic_mode) begin
               crc_in = cmux_pkg::crc_feed(crc_ff, len0_byte);
            end
         end
         cmux_pkg::ST_LEN1: begin
            res_item.out_byte = len1_byte;
            if (basic_mode) begin
               crc_in = cmux_pkg::crc_feed(crc_ff, len1_byte);
            end
         end
         cmux_pkg::ST_DATA: begin
            if (!frame_open_ff) begin
               res_item.error = 1'b1;
            end else begin
               res_item.out_byte = item_ff.data_byte;
               bytes_left_in     = left_dec;
               if (payload_in_crc_ff) begin
                  crc_in = cmux_pkg::crc_feed(crc_ff, item_ff.data_byte);
               end
            end
         end
         cmux_pkg::ST_FCS: begin
            res_item.out_byte = ~crc_ff;
         end
         cmux_pkg::ST_CLOSE: begin
            res_item.out_byte   = cmux_pkg::FLAG_BYTE;
            res_item.frame_last = 1'b1;
            frame_open_in       = 1'b0;
            bytes_left_in       = '0;
            payload_in_crc_in   = 1'b0;
            crc_in              = cmux_pkg::CRC_INIT;
         end
         default: begin
            res_item.out_byte = 8'h00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff     <= 1'b0;
         step_ff           <= cmux_pkg::ST_FLAG;
         crc_ff            <= cmux_pkg::CRC_INIT;
         bytes_left_ff     <= '0;
         frame_open_ff     <= 1'b0;
         payload_in_crc_ff <= 1'b0;
      end else begin
         if (advance) begin
            crc_ff            <= crc_in;
            bytes_left_ff     <= bytes_left_in;
            frame_open_ff     <= frame_open_in;
            payload_in_crc_ff <= payload_in_crc_in;
         end
         if (req_fire) begin
            item_valid_ff <= 1'b1;
            step_ff       <= (req_item.cmd == cmux_pkg::CMD_PAYLOAD) ?
                             cmux_pkg::ST_DATA : cmux_pkg::ST_FLAG;
         end else if (advance) begin
            if (step_end) begin
               item_valid_ff <= 1'b0;
            end else begin
               step_ff <= step_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
      end
   end

endmodule
